@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/ron_pkg.sv @@
// ---------------------------------------------------------------------------
// ron_pkg
// Types, mode and drive codes, and angle constants for the navigation block.
// ---------------------------------------------------------------------------
package ron_pkg;

    localparam int unsigned YawW  = 16;
    localparam int unsigned TickW = 16;
    localparam int unsigned TolW  = 15;
    localparam int unsigned ModeW = 3;
    localparam int unsigned CmdW  = 3;

    localparam logic [YawW-1:0] FULL_TURN    = 16'd36000;
    localparam logic [YawW-1:0] HALF_TURN    = 16'd18000;
    localparam logic [YawW-1:0] QUARTER_TURN = 16'd9000;
    localparam logic [YawW-1:0] THREE_QUARTER_TURN = 16'd27000;

    // navigation modes
    localparam logic [ModeW-1:0] M_FORWARD  = 3'd0;
    localparam logic [ModeW-1:0] M_REVERSE  = 3'd1;
    localparam logic [ModeW-1:0] M_RIGHT180 = 3'd2;
    localparam logic [ModeW-1:0] M_LEFT180  = 3'd3;
    localparam logic [ModeW-1:0] M_RIGHT90  = 3'd4;
    localparam logic [ModeW-1:0] M_LEFT90   = 3'd5;
    localparam logic [ModeW-1:0] M_TRAPPED  = 3'd6;
    localparam logic [ModeW-1:0] M_PAUSE    = 3'd7;

    // drive commands
    localparam logic [CmdW-1:0] D_FORWARD = 3'd0;
    localparam logic [CmdW-1:0] D_REVERSE = 3'd1;
    localparam logic [CmdW-1:0] D_LEFT    = 3'd2;
    localparam logic [CmdW-1:0] D_RIGHT   = 3'd3;
    localparam logic [CmdW-1:0] D_STOP    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_REVERSE_TICKS = 2'd0;
    localparam logic [1:0] CFG_PAUSE_TICKS   = 2'd1;
    localparam logic [1:0] CFG_HEADING_TOL   = 2'd2;
    localparam logic [1:0] CFG_HOME_HEADING  = 2'd3;

    localparam logic [TickW-1:0] RESET_REVERSE_TICKS = 16'd50;
    localparam logic [TickW-1:0] RESET_PAUSE_TICKS   = 16'd30;
    localparam logic [TolW-1:0]  RESET_HEADING_TOL   = 15'd300;
    localparam logic [YawW-1:0]  RESET_HOME_HEADING  = 16'd0;

    typedef struct packed {
        logic            kind;
        logic [YawW-1:0] yaw;
        logic            obs_front;
        logic            obs_right;
        logic            obs_left;
        logic            obs_back;
        logic            bump;
        logic            stuck;
    } t_item;

    typedef struct packed {
        logic [TickW-1:0] reverse_ticks;
        logic [TickW-1:0] pause_ticks;
        logic [TolW-1:0]  heading_tol;
        logic [YawW-1:0]  home_heading;
    } t_cfg;

    // heading candidates and turn status
    typedef struct packed {
        logic [YawW-1:0] goal_half;
        logic [YawW-1:0] goal_left90;
        logic [YawW-1:0] goal_right90;
        logic [YawW-1:0] goal_start;
        logic            turn_done;
    } t_hdg;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [ModeW-1:0] queued;
        logic [YawW-1:0]  goal;
        logic [TickW-1:0] rev_cnt;
        logic [TickW-1:0] pause_cnt;
    } t_nav;

endpackage

@@ hw/rtl/ron_heading.sv @@
// ---------------------------------------------------------------------------
// ron_heading
// Modulo-36000 heading arithmetic: new goal candidates and turn completion.
// ---------------------------------------------------------------------------
module ron_heading (
    input  ron_pkg::t_item item,
    input  ron_pkg::t_cfg  cfg,
    input  logic [ron_pkg::YawW-1:0] goal,
    output ron_pkg::t_hdg  hdg
);
    import ron_pkg::*;

    // one conditional subtract; valid for inputs below twice a full turn
    function automatic logic [YawW-1:0] wrap1(input logic [YawW:0] v);
        logic [YawW:0] d;
        d = v - {1'b0, FULL_TURN};
        return (v >= {1'b0, FULL_TURN}) ? d[YawW-1:0] : v[YawW-1:0];
    endfunction

    logic [YawW-1:0] yaw_m;
    logic [YawW-1:0] diff;
    logic [YawW-1:0] err;

    always_comb begin
        yaw_m            = wrap1({1'b0, item.yaw});
        hdg.goal_half    = wrap1({1'b0, yaw_m} + {1'b0, HALF_TURN});
        hdg.goal_left90  = wrap1({1'b0, yaw_m} + {1'b0, QUARTER_TURN});
        hdg.goal_right90 = wrap1({1'b0, yaw_m} + {1'b0, THREE_QUARTER_TURN});
        hdg.goal_start   = wrap1({1'b0, cfg.home_heading});

        // goal minus yaw, wrapped, then folded to the short way round
        diff = (goal >= yaw_m) ? (goal - yaw_m) : (goal + FULL_TURN - yaw_m);
        err  = (diff > HALF_TURN) ? (FULL_TURN - diff) : diff;
        hdg.turn_done = (err <= {1'b0, cfg.heading_tol});
    end

endmodule

@@ hw/rtl/ron_step.sv @@
// ---------------------------------------------------------------------------
// ron_step
// Mode transition logic: next navigation state and drive command per word.
// ---------------------------------------------------------------------------
module ron_step (
    input  ron_pkg::t_item item,
    input  ron_pkg::t_cfg  cfg,
    input  ron_pkg::t_hdg  hdg,
    input  ron_pkg::t_nav  cur,
    output ron_pkg::t_nav  nxt,
    output logic [ron_pkg::CmdW-1:0] cmd,
    output logic [ron_pkg::YawW-1:0] goal_out
);
    import ron_pkg::*;

    logic [TickW-1:0] rev_inc;
    logic [TickW-1:0] pause_inc;
    logic             go_pause;
    logic [ModeW-1:0] pause_next;

    always_comb begin
        nxt        = cur;
        cmd        = D_FORWARD;
        goal_out   = cur.goal;
        go_pause   = 1'b0;
        pause_next = M_FORWARD;
        rev_inc    = cur.rev_cnt + 1'b1;
        pause_inc  = cur.pause_cnt + 1'b1;

        if (item.kind) begin
            nxt.mode = M_FORWARD;
            nxt.goal = hdg.goal_start;
            goal_out = hdg.goal_start;
        end else begin
            case (cur.mode)
                M_FORWARD: begin
                    nxt.rev_cnt = '0;
                    cmd = D_FORWARD;
                    if (item.stuck || (item.obs_front && item.obs_left &&
                                       item.obs_right && item.obs_back)) begin
                        nxt.mode = M_TRAPPED;
                    end else if (item.bump || (item.obs_front && item.obs_left &&
                                               item.obs_right)) begin
                        go_pause   = 1'b1;
                        pause_next = M_REVERSE;
                    end else if (item.obs_front && item.obs_right) begin
                        nxt.goal   = hdg.goal_half;
                        go_pause   = 1'b1;
                        pause_next = M_LEFT180;
                    end else if (item.obs_front) begin
                        nxt.goal   = hdg.goal_half;
                        go_pause   = 1'b1;
                        pause_next = M_RIGHT180;
                    end
                end
                M_REVERSE: begin
                    cmd = D_REVERSE;
                    nxt.rev_cnt = rev_inc;
                    if (rev_inc > cfg.reverse_ticks) begin
                        nxt.rev_cnt = '0;
                        go_pause    = 1'b1;
                        if (!item.obs_left) begin
                            nxt.goal   = hdg.goal_left90;
                            pause_next = M_LEFT90;
                        end else if (!item.obs_right) begin
                            nxt.goal   = hdg.goal_right90;
                            pause_next = M_RIGHT90;
                        end else begin
                            nxt.goal   = hdg.goal_half;
                            pause_next = M_LEFT180;
                        end
                    end
                end
                M_PAUSE: begin
                    cmd = D_STOP;
                    nxt.pause_cnt = pause_inc;
                    if (pause_inc > cfg.pause_ticks) begin
                        nxt.mode = cur.queued;
                    end
                end
                M_TRAPPED: begin
                    cmd = D_STOP;
                    if (!item.obs_front || !item.obs_left || !item.obs_right ||
                        !item.obs_back) begin
                        nxt.mode = M_FORWARD;
                    end
                end
                default: begin
                    // the four turn modes
                    cmd = (cur.mode inside {M_LEFT90, M_LEFT180}) ? D_LEFT : D_RIGHT;
                    if (hdg.turn_done) begin
                        go_pause   = 1'b1;
                        pause_next = M_FORWARD;
                    end
                end
            endcase

            if (go_pause) begin
                nxt.mode      = M_PAUSE;
                nxt.queued    = pause_next;
                nxt.pause_cnt = '0;
            end
        end
    end

endmodule

@@ hw/rtl/reactive_obstacle_navigation_fsm_top.sv @@
// ---------------------------------------------------------------------------
// reactive_obstacle_navigation_fsm_top
// Obstacle-avoidance navigation controller with stream in and out.
// ---------------------------------------------------------------------------
// Each input word (a control tick or a restart) yields exactly one output
// word holding the drive command and the heading to hold. One word is taken
// per clock while the input is not stalled; the word is held in the input
// register, passes through the single-pass mode logic, and its result is
// presented from the result register. Backpressure on the output stalls
// the input once both stages are full. Configuration writes take effect
// from the next word and are meant to be made while the block is idle.
module reactive_obstacle_navigation_fsm_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] yaw, [16] obstacle_front, [17] obstacle_right, [18] obstacle_left,
    // [19] obstacle_back, [20] bump, [21] stuck, [23:22] zero
    input  logic [23:0] s_axis_tdata,
    // [0] kind
    input  logic [0:0]  s_axis_tuser,
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] drive_command, [18:3] target_yaw, [23:19] zero
    output logic [23:0] m_axis_tdata,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import ron_pkg::*;
    `include "assert_macros.svh"

    t_cfg             r_cfg;
    t_item            r_in;
    logic             r_in_vld;
    t_nav             r_nav;
    logic             r_out_vld;
    logic [CmdW-1:0]  r_out_cmd;
    logic [YawW-1:0]  r_out_yaw;

    t_hdg             hdg;
    t_nav             n_nav;
    logic [CmdW-1:0]  n_cmd;
    logic [YawW-1:0]  n_goal_out;
    logic             s_acc;
    logic             adv;

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || !r_out_vld || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out_yaw, r_out_cmd};

    ron_heading u_heading (
        .item (r_in),
        .cfg  (r_cfg),
        .goal (r_nav.goal),
        .hdg  (hdg)
    );

    ron_step u_step (
        .item     (r_in),
        .cfg      (r_cfg),
        .hdg      (hdg),
        .cur      (r_nav),
        .nxt      (n_nav),
        .cmd      (n_cmd),
        .goal_out (n_goal_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse_ticks <= RESET_REVERSE_TICKS;
            r_cfg.pause_ticks   <= RESET_PAUSE_TICKS;
            r_cfg.heading_tol   <= RESET_HEADING_TOL;
            r_cfg.home_heading  <= RESET_HOME_HEADING;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_REVERSE_TICKS: r_cfg.reverse_ticks <= i_cfg_wdata;
                CFG_PAUSE_TICKS:   r_cfg.pause_ticks   <= i_cfg_wdata;
                CFG_HEADING_TOL:   r_cfg.heading_tol   <= i_cfg_wdata[TolW-1:0];
                CFG_HOME_HEADING:  r_cfg.home_heading  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_acc) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in.kind      <= s_axis_tuser[0];
            r_in.yaw       <= s_axis_tdata[15:0];
            r_in.obs_front <= s_axis_tdata[16];
            r_in.obs_right <= s_axis_tdata[17];
            r_in.obs_left  <= s_axis_tdata[18];
            r_in.obs_back  <= s_axis_tdata[19];
            r_in.bump      <= s_axis_tdata[20];
            r_in.stuck     <= s_axis_tdata[21];
        end
    end

    // navigation state, advanced once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nav.mode      <= M_FORWARD;
            r_nav.queued    <= M_FORWARD;
            r_nav.goal      <= RESET_HOME_HEADING;
            r_nav.rev_cnt   <= '0;
            r_nav.pause_cnt <= '0;
        end else if (adv) begin
            r_nav <= n_nav;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_cmd <= n_cmd;
            r_out_yaw <= n_goal_out;
        end
    end

    `ASSERT_IMPL(a_stall_full, !s_axis_tready, r_in_vld && r_out_vld)
    `ASSERT_IMPL(a_goal_range, 1'b1, r_nav.goal < FULL_TURN)
    `ASSERT_NEXT(a_restart_fwd, adv && r_in.kind,
                 r_nav.mode == M_FORWARD && r_out_cmd == D_FORWARD && r_out_vld)
    `ASSERT_NEXT(a_pause_clear, adv && n_nav.mode == M_PAUSE && r_nav.mode != M_PAUSE,
                 r_nav.pause_cnt == '0)

endmodule
